### design/brts_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear RGB table sampler package
// Shared constants, item codes and the RGB entry type.
// ----------------------------------------------------------------------------
package brts_pkg;

  localparam int DEF_TABLE_ROWS = 91;
  localparam int DEF_TABLE_COLS = 181;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int CH_W = 16;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

### design/brts_bank.sv
// ----------------------------------------------------------------------------
// Table bank
// One parity bank of the color table: one write port and one read port with
// a registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module brts_bank
  import brts_pkg::*;
#(
  parameter int DEPTH = 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rgb_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rgb_t          rd_data
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/brts_lerp3.sv
// ----------------------------------------------------------------------------
// Three-channel linear interpolation stage
// Registers ((2^F - f) * a + f * b) >> F for red, green and blue, computed
// as (a * 2^F + f * (b - a)) >> F with one multiplier per channel.
// ----------------------------------------------------------------------------
module brts_lerp3
  import brts_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  rgb_t                 a,
  input  rgb_t                 b,
  input  logic [FRAC_BITS-1:0] f,
  output rgb_t                 q
);

  localparam int SW = CH_W + FRAC_BITS + 2;

  function automatic logic [CH_W-1:0] lerp_ch(input logic [CH_W-1:0] va,
                                              input logic [CH_W-1:0] vb,
                                              input logic [FRAC_BITS-1:0] vf);
    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] prod;
    logic signed [SW-1:0] sum;
    diff = $signed(SW'(vb)) - $signed(SW'(va));
    prod = diff * $signed(SW'(vf));
    sum  = ($signed(SW'(va)) <<< FRAC_BITS) + prod;
    return CH_W'(sum >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q.red   <= lerp_ch(a.red,   b.red,   f);
      q.green <= lerp_ch(a.green, b.green, f);
      q.blue  <= lerp_ch(a.blue,  b.blue,  f);
    end
  end

endmodule

### design/bilinear_rgb_table_sampler.sv
// ----------------------------------------------------------------------------
// Bilinear RGB table sampler
// A lookup beat passes through registered stages for the bank read, the row
// blend and the column blend, in that order. Throughput: one beat per
// cycle unless out_ready stalls; four parity banks give four reads a cycle.
// Reset clears the pipeline valid bits only; table contents are undefined
// until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_rgb_table_sampler
  import brts_pkg::*;
#(
  parameter int TABLE_ROWS = DEF_TABLE_ROWS,
  parameter int TABLE_COLS = DEF_TABLE_COLS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [6:0]  in_entry_row,
  input  logic [7:0]  in_entry_col,
  input  logic [15:0] in_entry_red,
  input  logic [15:0] in_entry_green,
  input  logic [15:0] in_entry_blue,
  input  logic [14:0] in_row_coord,
  input  logic [15:0] in_col_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue
);

  localparam int RW    = $clog2(TABLE_ROWS);
  localparam int CW    = $clog2(TABLE_COLS);
  localparam int HR    = TABLE_ROWS / 2 + 1;
  localparam int HC    = TABLE_COLS / 2 + 1;
  localparam int RHW   = $clog2(HR);
  localparam int CHW   = $clog2(HC);
  localparam int DEPTH = HR * HC;
  localparam int AW    = $clog2(DEPTH);

  logic e1, e2, e3;
  logic accept;
  logic v1_r, v1_nxt, v2_r, out_valid_r;

  assign e3       = !out_valid_r || out_ready;
  assign e2       = !v2_r || e3;
  assign e1       = !v1_r || e2;
  assign in_ready = e1;
  assign accept   = in_valid && e1;
  assign v1_nxt   = accept && (in_mode == MODE_LOOKUP);

  logic [14:0]          row_ip;
  logic [15:0]          col_ip;
  logic                 row_sat, col_sat;
  logic [RW-1:0]        x0;
  logic [CW-1:0]        y0;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [RHW-1:0]       rh [2];
  logic [CHW-1:0]       ch [2];

  assign row_ip  = in_row_coord >> FRAC_BITS;
  assign col_ip  = in_col_coord >> FRAC_BITS;
  assign row_sat = 32'(row_ip) >= 32'(TABLE_ROWS - 1);
  assign col_sat = 32'(col_ip) >= 32'(TABLE_COLS - 1);
  assign x0      = row_sat ? RW'(TABLE_ROWS - 1) : RW'(row_ip);
  assign y0      = col_sat ? CW'(TABLE_COLS - 1) : CW'(col_ip);
  assign fx      = row_sat ? '0 : FRAC_BITS'(in_row_coord);
  assign fy      = col_sat ? '0 : FRAC_BITS'(in_col_coord);

  for (genvar p = 0; p < 2; p++) begin : g_half
    logic [RW:0] rp;
    logic [CW:0] cp;
    assign rp    = {1'b0, x0} + (RW+1)'(x0[0] != 1'(p));
    assign cp    = {1'b0, y0} + (CW+1)'(y0[0] != 1'(p));
    assign rh[p] = RHW'(rp >> 1);
    assign ch[p] = CHW'(cp >> 1);
  end

  logic          wr_ok;
  logic [1:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [3:0]    bank_we;
  rgb_t          wr_data;
  rgb_t          rd [4];

  assign wr_ok = accept && (in_mode == MODE_LOAD) &&
                 (32'(in_entry_row) < 32'(TABLE_ROWS)) &&
                 (32'(in_entry_col) < 32'(TABLE_COLS));
  assign wr_bank = {in_entry_row[0], in_entry_col[0]};
  assign wr_addr = AW'(32'(in_entry_row >> 1) * HC + 32'(in_entry_col >> 1));
  assign wr_data = '{red: in_entry_red, green: in_entry_green, blue: in_entry_blue};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [AW-1:0] rd_addr;
    assign rd_addr    = AW'(32'(rh[b/2]) * HC + 32'(ch[b%2]));
    assign bank_we[b] = wr_ok && (wr_bank == 2'(b));
    brts_bank #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (bank_we[b]),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (e1),
      .rd_addr (rd_addr),
      .rd_data (rd[b])
    );
  end

  logic                 xp_r, yp_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e1) begin
        v1_r <= v1_nxt;
      end
      if (e2) begin
        v2_r <= v1_r;
      end
      if (e3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      xp_r <= x0[0];
      yp_r <= y0[0];
      fx_r <= fx;
      fy_r <= fy;
    end
    if (e2) begin
      fy2_r <= fy_r;
    end
  end

  // With a zero fraction the far corner is the near one, as in the table.
  rgb_t c00, c10, c01, c11;
  assign c00 = rd[{xp_r, yp_r}];
  assign c10 = (fx_r != '0) ? rd[{~xp_r, yp_r}] : c00;
  assign c01 = (fy_r != '0) ? rd[{xp_r, ~yp_r}] : c00;
  assign c11 = (fx_r != '0) ? ((fy_r != '0) ? rd[{~xp_r, ~yp_r}] : c10) : c01;

  rgb_t t0, t1, out_q;

  brts_lerp3 #(.FRAC_BITS(FRAC_BITS)) u_lerp_row0 (
    .clk (clk), .en (e2), .a (c00), .b (c10), .f (fx_r), .q (t0)
  );

  brts_lerp3 #(.FRAC_BITS(FRAC_BITS)) u_lerp_row1 (
    .clk (clk), .en (e2), .a (c01), .b (c11), .f (fx_r), .q (t1)
  );

  brts_lerp3 #(.FRAC_BITS(FRAC_BITS)) u_lerp_col (
    .clk (clk), .en (e3), .a (t0), .b (t1), .f (fy2_r), .q (out_q)
  );

  assign out_valid = out_valid_r;
  assign out_red   = out_q.red;
  assign out_green = out_q.green;
  assign out_blue  = out_q.blue;

`ifndef SYNTH
  a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_LOOKUP) |=> v1_r)
    else $error("Accepted lookup did not enter the read stage.");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_LOAD) |=> !v1_r)
    else $error("Load beat entered the lookup pipeline.");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && out_valid_r && !out_ready) |=> v2_r)
    else $error("Interpolation stage dropped a beat during a stall.");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("More than one bank written in a cycle.");
`endif

endmodule
